[rtl/core/qrsqrt_pkg.sv]
package qrsqrt_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueueAw = 2;

    localparam logic [31:0] ThreeQ16 = 32'd3 << 16;
    localparam logic [63:0] HalfQ16  = 64'd1 << 15;
    localparam logic [63:0] OneQ16   = 64'd1 << 16;

    typedef struct packed {
        logic        zero;
        logic [31:0] x;
        logic [31:0] y0;
    } seed_t;

    function automatic logic [31:0] root_rom(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd65535;
            5'd1:  v = 32'd46341;
            5'd2:  v = 32'd32768;
            5'd3:  v = 32'd23170;
            5'd4:  v = 32'd16384;
            5'd5:  v = 32'd11585;
            5'd6:  v = 32'd8192;
            5'd7:  v = 32'd5793;
            5'd8:  v = 32'd4096;
            5'd9:  v = 32'd2896;
            5'd10: v = 32'd2048;
            5'd11: v = 32'd1448;
            5'd12: v = 32'd1024;
            5'd13: v = 32'd724;
            5'd14: v = 32'd512;
            5'd15: v = 32'd362;
            5'd16: v = 32'd256;
            5'd17: v = 32'd181;
            5'd18: v = 32'd128;
            5'd19: v = 32'd90;
            5'd20: v = 32'd64;
            5'd21: v = 32'd45;
            5'd22: v = 32'd32;
            5'd23: v = 32'd23;
            5'd24: v = 32'd16;
            5'd25: v = 32'd11;
            5'd26: v = 32'd8;
            5'd27: v = 32'd6;
            5'd28: v = 32'd4;
            5'd29: v = 32'd3;
            5'd30: v = 32'd2;
            default: v = 32'd1;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/qrsqrt_if.sv]
interface qrsqrt_if;
    import qrsqrt_pkg::*;
    logic             valid;
    logic             ready;
    logic [DataW-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/qrsqrt_front.sv]
module qrsqrt_front
    import qrsqrt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    qrsqrt_if.sink operand,
    output logic  seed_valid,
    input  logic  seed_ready,
    output seed_t seed
);

    logic        s1_valid_reg;
    logic [31:0] s1_x_reg;
    logic [31:0] s1_frac_reg;
    logic [31:0] s1_base_reg;
    logic [31:0] s1_delta_reg;
    logic        s2_valid_reg;
    seed_t       s2_reg;

    logic [4:0]  e_c;
    logic [31:0] sub_c;
    logic [63:0] frac_c;
    logic [31:0] next_c;
    logic [63:0] prod_c;
    logic        s2_adv;
    logic        s1_adv;

    always_comb
    begin
        e_c = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (operand.data[i])
            begin
                e_c = 5'(i);
            end
        end
    end

    // top exponent subtracts no base and takes 1 as next value
    assign sub_c  = (e_c == 5'd31) ? 32'd0 : (32'd1 << e_c);
    assign frac_c = ({32'd0, operand.data - sub_c} << 16) >> e_c;
    assign next_c = (e_c == 5'd31) ? 32'd1 : root_rom(e_c + 5'd1);
    assign prod_c = {32'd0, s1_delta_reg} * {32'd0, s1_frac_reg};

    assign s2_adv = !s2_valid_reg || seed_ready;
    assign s1_adv = !s1_valid_reg || s2_adv;
    assign operand.ready = s1_adv;
    assign seed_valid = s2_valid_reg;
    assign seed = s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= operand.valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && operand.valid)
        begin
            s1_x_reg     <= operand.data;
            s1_frac_reg  <= frac_c[31:0];
            s1_base_reg  <= root_rom(e_c);
            s1_delta_reg <= root_rom(e_c) - next_c;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_reg.zero <= (s1_x_reg == 32'd0);
            s2_reg.x    <= s1_x_reg;
            s2_reg.y0   <= s1_base_reg - prod_c[47:16];
        end
    end

endmodule

[rtl/core/qrsqrt_queue.sv]
module qrsqrt_queue
    import qrsqrt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  seed_t wr_data,
    output logic  rd_valid,
    input  logic  rd_ready,
    output seed_t rd_data
);

    seed_t              mem_reg [QueueDepth];
    logic [QueueAw-1:0] wr_ptr_reg;
    logic [QueueAw-1:0] rd_ptr_reg;
    logic [QueueAw:0]   count_reg;
    logic               push;
    logic               pop;

    assign wr_ready = (count_reg != (QueueAw+1)'(QueueDepth));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/core/qrsqrt_newton.sv]
module qrsqrt_newton
    import qrsqrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  seed_t       in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output seed_t       out_data
);

    // stage a: y*y; stage b: x*lo, x*hi; stage c: term; stage d: y*term
    logic        a_v_reg, b_v_reg, c_v_reg, d_v_reg;
    seed_t       a_reg, b_reg, c_reg, d_reg;
    logic [63:0] a_sq_reg;
    logic [63:0] b_plo_reg, b_phi_reg;
    logic [31:0] c_term_reg;
    logic        adv;
    logic [63:0] s64_c;
    logic [63:0] p_c;

    assign adv = !d_v_reg || out_ready;
    assign in_ready = adv;
    assign out_valid = d_v_reg;
    assign out_data = d_reg;

    assign s64_c = (b_phi_reg << 16) + ((b_plo_reg + HalfQ16) >> 16);
    assign p_c = {32'd0, c_reg.y0} * {32'd0, c_term_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg      <= in_data;
            a_sq_reg   <= {32'd0, in_data.y0} * {32'd0, in_data.y0};
            b_reg      <= a_reg;
            b_plo_reg  <= {32'd0, a_reg.x} * {32'd0, a_sq_reg[31:0]};
            b_phi_reg  <= {32'd0, a_reg.x} * {32'd0, a_sq_reg[63:32]};
            c_reg      <= b_reg;
            c_term_reg <= ThreeQ16 - s64_c[31:0];
            d_reg.zero <= c_reg.zero;
            d_reg.x    <= c_reg.x;
            d_reg.y0   <= 32'((p_c + OneQ16) >> 17);
        end
    end

endmodule

[rtl/core/q16_reciprocal_square_root.sv]
// Q16 reciprocal square root: recip_root ~ 2^16/sqrt(operand), 0 for operand 0.
// One operand is accepted every cycle unless back-pressure stalls; each operand
// passes two registered seed lookup and interpolation stages, the queue, two
// Newton steps (4 multiply stages each) and the output register. A 4-entry queue
// parts the seed front end from the Newton back end so each stalls on its own.
module q16_reciprocal_square_root
    import qrsqrt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    qrsqrt_if.sink   operand,
    qrsqrt_if.source recip_root
);

    logic  f_v, f_r, q_v, q_r, n1_v, n1_r, n2_v, n2_r;
    seed_t f_d, q_d, n1_d, n2_d;
    logic        out_v_reg;
    logic [31:0] out_d_reg;

    qrsqrt_front u_front (
        .clk(clk), .rst_n(rst_n), .operand(operand),
        .seed_valid(f_v), .seed_ready(f_r), .seed(f_d)
    );

    qrsqrt_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_v), .wr_ready(f_r), .wr_data(f_d),
        .rd_valid(q_v), .rd_ready(q_r), .rd_data(q_d)
    );

    qrsqrt_newton u_step1 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(q_v), .in_ready(q_r), .in_data(q_d),
        .out_valid(n1_v), .out_ready(n1_r), .out_data(n1_d)
    );

    qrsqrt_newton u_step2 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(n1_v), .in_ready(n1_r), .in_data(n1_d),
        .out_valid(n2_v), .out_ready(n2_r), .out_data(n2_d)
    );

    assign n2_r = !out_v_reg || recip_root.ready;
    assign recip_root.valid = out_v_reg;
    assign recip_root.data = out_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (n2_r)
        begin
            out_v_reg <= n2_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n2_r && n2_v)
        begin
            out_d_reg <= n2_d.zero ? 32'd0 : n2_d.y0;
        end
    end

endmodule
